// ----- hw/rtl/hitg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hitg_pkg
// Shared types and constants for the interrupt/timer glue block.
// ----------------------------------------------------------------------------
package hitg_pkg;

  localparam int unsigned PeriodW   = 13;
  localparam int unsigned IncW      = 8;
  localparam int unsigned PrescW    = 9;
  localparam int unsigned TbW       = 4;
  localparam int unsigned KeysW     = 16;
  localparam int unsigned EnW       = 5;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;

  localparam logic [PeriodW-1:0] PeriodReset = 13'd6000;
  localparam logic [IncW-1:0]    IncReset    = 8'd3;
  localparam logic [PrescW-1:0]  PrescLimit  = 9'd255;

  // Register index (byte address bit 2)
  localparam logic RegStepPeriod = 1'b0;
  localparam logic RegPrescInc   = 1'b1;

  // Item kinds
  localparam logic FuncStep   = 1'b0;
  localparam logic FuncKeypad = 1'b1;

  // Key used as shift for the watchdog arm sequence
  localparam int unsigned KeyShiftBit = 2;

  // Enable register bits
  localparam int unsigned EnResetBit    = 0;
  localparam int unsigned EnTimebaseBit = 3;
  localparam int unsigned EnTimer0Bit   = 4;

  typedef struct packed {
    logic               irq_pending;
    logic               watchdog_pending;
    logic [PeriodW-1:0] step_count;
    logic [PrescW-1:0]  prescale_count;
    logic               shift_latch;
  } hitg_state_t;

  typedef struct packed {
    logic           take_nmi;
    logic           take_irq;
    logic [EnW-1:0] enable_bits_set;
    logic           timer_bit_set;
    logic           reset_to_vector;
  } hitg_result_t;

  typedef struct packed {
    logic             func;
    logic             half_second_tick;
    logic             cpu_irq_masked;
    logic             timer_running;
    logic [TbW-1:0]   timebase_select;
    logic [KeysW-1:0] low_rows_keys;
  } hitg_item_t;

endpackage : hitg_pkg
`default_nettype wire

// ----- hw/rtl/hitg_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hitg_core
// Next-state and result logic for one item; purely combinational.
// ----------------------------------------------------------------------------
module hitg_core
  import hitg_pkg::*;
(
  input  wire hitg_item_t          item,
  input  wire hitg_state_t         st,
  input  wire logic [PeriodW-1:0]  step_period,
  input  wire logic [IncW-1:0]     prescale_increment,
  output hitg_state_t              st_nxt,
  output hitg_result_t             res
);

  logic             took;
  logic             wrap;
  logic             adv;
  logic             tb_on;
  logic [PeriodW:0] cnt_inc;
  logic [PrescW-1:0] psum;

  assign tb_on   = (item.timebase_select != '0);
  assign cnt_inc = {1'b0, st.step_count} + {{PeriodW{1'b0}}, 1'b1};
  assign psum    = st.prescale_count + {{(PrescW-IncW){1'b0}}, prescale_increment};

  always_comb begin
    st_nxt = st;
    res    = '0;
    took   = 1'b0;
    wrap   = 1'b0;
    adv    = 1'b0;
    if (item.func == FuncKeypad) begin
      if (st.shift_latch) begin
        if (item.low_rows_keys != '0) begin
          st_nxt.watchdog_pending = 1'b1;
          st_nxt.shift_latch      = 1'b0;
        end
      end else if (item.low_rows_keys[KeyShiftBit]) begin
        st_nxt.shift_latch = 1'b1;
      end
    end else begin
      if (item.half_second_tick) begin
        res.take_nmi = 1'b1;
        took         = 1'b1;
      end else if (!item.cpu_irq_masked && st.irq_pending) begin
        st_nxt.irq_pending = 1'b0;
        res.take_irq       = 1'b1;
        took               = 1'b1;
      end
      wrap = !took && (cnt_inc >= {1'b0, step_period});
      if (wrap) begin
        st_nxt.step_count = '0;
        if (st.watchdog_pending) begin
          res.enable_bits_set[EnResetBit] = 1'b1;
          res.timer_bit_set               = 1'b1;
          res.reset_to_vector             = 1'b1;
          st_nxt.watchdog_pending         = 1'b0;
        end else begin
          if (tb_on) begin
            st_nxt.irq_pending                 = 1'b1;
            res.enable_bits_set[EnTimebaseBit] = 1'b1;
          end
          adv = 1'b1;
        end
      end else begin
        if (!took) begin
          st_nxt.step_count = cnt_inc[PeriodW-1:0];
        end
        adv = 1'b1;
      end
      // timer0 prescaler
      if (adv && item.timer_running) begin
        if (psum >= PrescLimit) begin
          st_nxt.prescale_count = '0;
          if (tb_on) begin
            st_nxt.irq_pending               = 1'b1;
            res.enable_bits_set[EnTimer0Bit] = 1'b1;
          end
        end else begin
          st_nxt.prescale_count = psum;
        end
      end
    end
  end

endmodule : hitg_core
`default_nettype wire

// ----- hw/rtl/handheld_interrupt_timer_glue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// handheld_interrupt_timer_glue
// Interrupt and timer glue for an emulated 65C02 handheld.
// ----------------------------------------------------------------------------
// One input transfer per emulated instruction step or keypad update, one
// result transfer per input. The block takes one item per clock while in_stall
// is low: an item's flag and counter updates go into the state and output
// registers, so its result is valid in the next cycle. The single output
// register is the only buffering: a new item is accepted while the output is
// empty or being drained in the same cycle, so in_stall follows out_stall only
// while a result is waiting. Configuration (step_period at 0x0,
// prescale_increment at 0x4) goes over the APB-style port; the user writes it
// only while the block is idle, unenforced by the block. pready is tied high.
// ----------------------------------------------------------------------------
module handheld_interrupt_timer_glue
  import hitg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic              in_func,
  input  wire logic              in_half_second_tick,
  input  wire logic              in_cpu_irq_masked,
  input  wire logic              in_timer_running,
  input  wire logic [TbW-1:0]    in_timebase_select,
  input  wire logic [KeysW-1:0]  in_low_rows_keys,
  // result channel
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic              out_take_nmi,
  output      logic              out_take_irq,
  output      logic [EnW-1:0]    out_enable_bits_set,
  output      logic              out_timer_bit_set,
  output      logic              out_reset_to_vector,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output      logic [PdataW-1:0] prdata,
  output      logic              pready
);

  // configuration registers
  logic [PeriodW-1:0] step_period_r;
  logic [IncW-1:0]    prescale_inc_r;
  logic               cfg_wr;

  // block state and output register
  hitg_state_t  st_r, st_nxt;
  hitg_result_t res_r, res_nxt;
  logic         out_valid_r, out_valid_nxt;
  hitg_item_t   item;
  logic         in_xfer;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Only address bit 2 picks the register; the low byte-lane bits are ignored.
  always_comb begin
    unique case (paddr[2])
      RegStepPeriod: prdata = {{(PdataW-PeriodW){1'b0}}, step_period_r};
      RegPrescInc:   prdata = {{(PdataW-IncW){1'b0}}, prescale_inc_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r  <= PeriodReset;
      prescale_inc_r <= IncReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegStepPeriod) begin
        step_period_r <= pwdata[PeriodW-1:0];
      end else begin
        prescale_inc_r <= pwdata[IncW-1:0];
      end
    end
  end

  // Accept while the output register is empty or drains this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign item.func             = in_func;
  assign item.half_second_tick = in_half_second_tick;
  assign item.cpu_irq_masked   = in_cpu_irq_masked;
  assign item.timer_running    = in_timer_running;
  assign item.timebase_select  = in_timebase_select;
  assign item.low_rows_keys    = in_low_rows_keys;

  hitg_core u_core (
    .item               (item),
    .st                 (st_r),
    .step_period        (step_period_r),
    .prescale_increment (prescale_inc_r),
    .st_nxt             (st_nxt),
    .res                (res_nxt)
  );

  always_comb begin
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_take_nmi        = res_r.take_nmi;
  assign out_take_irq        = res_r.take_irq;
  assign out_enable_bits_set = res_r.enable_bits_set;
  assign out_timer_bit_set   = res_r.timer_bit_set;
  assign out_reset_to_vector = res_r.reset_to_vector;

endmodule : handheld_interrupt_timer_glue
`default_nettype wire

// ----- hw/rtl/hitg_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hitg_checker
// Port-level checks for the interrupt/timer glue, bound to the top level.
// ----------------------------------------------------------------------------
module hitg_checker
  import hitg_pkg::*;
(
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire logic           out_take_nmi,
  input wire logic           out_take_irq,
  input wire logic [EnW-1:0] out_enable_bits_set,
  input wire logic           out_timer_bit_set,
  input wire logic           out_reset_to_vector
);

  // a waiting result holds across a stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // with the only output slot full and stalled, input must stall
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken with output full");

  a_one_int: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_take_nmi && out_take_irq))
    else $error("NMI and IRQ on one step");

  a_wdog_reset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reset_to_vector |->
      out_timer_bit_set && !out_take_nmi && !out_take_irq &&
      (out_enable_bits_set == 5'b00001))
    else $error("bad reset-to-vector result");

  a_tbit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_timer_bit_set == out_reset_to_vector))
    else $error("timer bit without reset path");

endmodule : hitg_checker

bind handheld_interrupt_timer_glue hitg_checker u_hitg_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_take_nmi        (out_take_nmi),
  .out_take_irq        (out_take_irq),
  .out_enable_bits_set (out_enable_bits_set),
  .out_timer_bit_set   (out_timer_bit_set),
  .out_reset_to_vector (out_reset_to_vector)
);
`default_nettype wire
